// ----- rtl/mi3_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies.
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int COF_W  = 2 * ELEM_W + 1;
  localparam int DET_W  = 3 * ELEM_W + 3;
  localparam int NUM_W  = COF_W + 2 * FRAC_W;
  localparam int REM_W  = (NUM_W > DET_W + ELEM_W + 1) ? NUM_W : DET_W + ELEM_W + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] res;
    logic                     sat;
    logic                     zero;
  } lane_out_t;

endpackage

// ----- rtl/mi3_det.sv -----
// Determinant by the rule of Sarrus, four pipeline stages.
// Depends on mi3_pkg.
module mi3_det (
  input  logic                               clk,
  input  logic                               en,
  input  mi3_pkg::in_t                       m,
  output logic signed [mi3_pkg::DET_W-1:0]   det
);

  localparam int W  = mi3_pkg::ELEM_W;
  localparam int DW = mi3_pkg::DET_W;

  logic signed [W-1:0]     fa [6];
  logic signed [W-1:0]     fb [6];
  logic signed [W-1:0]     fc [6];
  logic signed [2*W-1:0]   ab_r [6];
  logic signed [W-1:0]     c1_r [6];
  logic signed [2*W:0]     lo_r [6];
  logic signed [2*W-1:0]   hi_r [6];
  logic signed [3*W-1:0]   tr_r [6];
  logic signed [DW-1:0]    det_r;

  always_comb begin
    fa[0] = m.m00; fb[0] = m.m11; fc[0] = m.m22;
    fa[1] = m.m01; fb[1] = m.m12; fc[1] = m.m20;
    fa[2] = m.m02; fb[2] = m.m10; fc[2] = m.m21;
    fa[3] = m.m02; fb[3] = m.m11; fc[3] = m.m20;
    fa[4] = m.m01; fb[4] = m.m10; fc[4] = m.m22;
    fa[5] = m.m00; fb[5] = m.m12; fc[5] = m.m21;
  end

  for (genvar k = 0; k < 6; k++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        ab_r[k] <= fa[k] * fb[k];
        c1_r[k] <= fc[k];
        lo_r[k] <= $signed({1'b0, ab_r[k][W-1:0]}) * c1_r[k];
        hi_r[k] <= $signed(ab_r[k][2*W-1:W]) * c1_r[k];
        tr_r[k] <= $signed({hi_r[k], {W{1'b0}}}) + (3*W)'(lo_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= DW'(tr_r[0]) + DW'(tr_r[1]) + DW'(tr_r[2])
             - DW'(tr_r[3]) - DW'(tr_r[4]) - DW'(tr_r[5]);
    end
  end

  assign det = det_r;

endmodule

// ----- rtl/mi3_lane.sv -----
// One inverse element: cofactor, magnitude, pipelined restoring divide, saturation.
// Depends on mi3_pkg; takes the determinant from mi3_det, aligned at stage four.
module mi3_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [mi3_pkg::ELEM_W-1:0] a,
  input  logic signed [mi3_pkg::ELEM_W-1:0] b,
  input  logic signed [mi3_pkg::ELEM_W-1:0] c,
  input  logic signed [mi3_pkg::ELEM_W-1:0] d,
  input  logic signed [mi3_pkg::DET_W-1:0]  det,
  output mi3_pkg::lane_out_t                res
);

  localparam int W  = mi3_pkg::ELEM_W;
  localparam int F  = mi3_pkg::FRAC_W;
  localparam int CW = mi3_pkg::COF_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int RW = mi3_pkg::REM_W;

  logic signed [2*W-1:0] p1_r, p2_r;
  logic signed [CW-1:0]  cof_r, cof2_r, cof3_r;
  logic [CW-1:0]         cmag;
  logic [DW-1:0]         dmag;
  logic [RW-1:0]         n5_r, d5_r;
  logic                  neg5_r, zero5_r;
  logic [RW-1:0]         rr_r [W+1];
  logic [RW-1:0]         dd_r [W+1];
  logic [W-1:0]          qq_r [W+1];
  logic                  neg_r [W+1];
  logic                  zero_r [W+1];
  logic                  ovf_r [W+1];
  mi3_pkg::lane_out_t    res_r, res_nxt;

  assign cmag = cof3_r[CW-1] ? CW'(-cof3_r) : CW'(cof3_r);
  assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= a * b;
      p2_r    <= c * d;
      cof_r   <= CW'(p1_r) - CW'(p2_r);
      cof2_r  <= cof_r;
      cof3_r  <= cof2_r;
      n5_r    <= RW'(cmag) << (2 * F);
      d5_r    <= RW'(dmag);
      neg5_r  <= cof3_r[CW-1] ^ det[DW-1];
      zero5_r <= (det == '0);
      rr_r[0]   <= n5_r;
      dd_r[0]   <= d5_r;
      qq_r[0]   <= '0;
      neg_r[0]  <= neg5_r;
      zero_r[0] <= zero5_r;
      ovf_r[0]  <= (n5_r >= (d5_r << W));
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int B = W - 1 - k;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = dd_r[k] << B;
    assign ge = (rr_r[k] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rr_r[k+1]   <= ge ? rr_r[k] - sh : rr_r[k];
        qq_r[k+1]   <= qq_r[k] | (W'(ge) << B);
        dd_r[k+1]   <= dd_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  always_comb begin
    logic [W-1:0] q;
    logic         big;
    q   = qq_r[W];
    big = neg_r[W] ? (q[W-1] && (q[W-2:0] != '0)) : q[W-1];
    res_nxt.zero = zero_r[W];
    if (zero_r[W]) begin
      res_nxt.res = '0;
      res_nxt.sat = 1'b0;
    end else if (ovf_r[W] || big) begin
      res_nxt.sat = 1'b1;
      res_nxt.res = neg_r[W] ? $signed({1'b1, {(W-1){1'b0}}})
                             : $signed({1'b0, {(W-1){1'b1}}});
    end else begin
      res_nxt.sat = 1'b0;
      res_nxt.res = neg_r[W] ? $signed(-q) : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/matrix_inverse_3x3_top.sv -----
// 3x3 matrix inverse top: determinant unit, nine cofactor/divide lanes, status merge.
// One item per cycle unless the output stalls, set by the pipelined
// divider in each lane. A stalled output holds the whole pipeline.
// Reset (rst_n, synchronous) clears the valid bits only.
// Depends on mi3_pkg, mi3_det, mi3_lane.
module matrix_inverse_3x3_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mi3_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mi3_pkg::out_t out_data
);

  localparam int W   = mi3_pkg::ELEM_W;
  localparam int LAT = W + 7;

  logic                             en;
  logic [LAT-1:0]                   v_r, v_nxt;
  logic signed [mi3_pkg::DET_W-1:0] det;
  logic signed [W-1:0]              e [3][3];
  mi3_pkg::lane_out_t               lo [9];
  logic                             any_sat;

  assign en       = !(v_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign v_nxt    = en ? {v_r[LAT-2:0], in_valid} : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign e[0][0] = in_data.m00; assign e[0][1] = in_data.m01; assign e[0][2] = in_data.m02;
  assign e[1][0] = in_data.m10; assign e[1][1] = in_data.m11; assign e[1][2] = in_data.m12;
  assign e[2][0] = in_data.m20; assign e[2][1] = in_data.m21; assign e[2][2] = in_data.m22;

  mi3_det u_det (
    .clk (clk),
    .en  (en),
    .m   (in_data),
    .det (det)
  );

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mi3_lane u_lane (
        .clk (clk),
        .en  (en),
        .a   (e[(j+1)%3][(i+1)%3]),
        .b   (e[(j+2)%3][(i+2)%3]),
        .c   (e[(j+2)%3][(i+1)%3]),
        .d   (e[(j+1)%3][(i+2)%3]),
        .det (det),
        .res (lo[i*3+j])
      );
    end
  end

  assign any_sat = lo[0].sat | lo[1].sat | lo[2].sat | lo[3].sat | lo[4].sat
                 | lo[5].sat | lo[6].sat | lo[7].sat | lo[8].sat;

  assign out_valid       = v_r[LAT-1];
  assign out_data.r00    = lo[0].res;
  assign out_data.r01    = lo[1].res;
  assign out_data.r02    = lo[2].res;
  assign out_data.r10    = lo[3].res;
  assign out_data.r11    = lo[4].res;
  assign out_data.r12    = lo[5].res;
  assign out_data.r20    = lo[6].res;
  assign out_data.r21    = lo[7].res;
  assign out_data.r22    = lo[8].res;
  assign out_data.status = lo[0].zero ? mi3_pkg::ST_SINGULAR
                         : (any_sat ? mi3_pkg::ST_SAT : mi3_pkg::ST_OK);

endmodule
